FILE: design/focsv_pkg.sv
// Shared constants, sine table, command types and helpers for the FOC current loop.
`default_nettype none
package focsv_pkg;

    localparam int SINE_ENTRIES = 1024;
    localparam int ANGLE_BITS   = 16;

    // Table index: two quadrant bits above the offset within a quarter wave
    localparam int K_W    = $clog2(SINE_ENTRIES);
    localparam int IDX_W  = K_W + 2;
    localparam int ADDR_W = K_W + 1;

    localparam int MUL_W  = 28;
    localparam int PROD_W = 2 * MUL_W;
    localparam int V_W    = 28;
    localparam int N_W    = V_W + 2;
    localparam int U_W    = 44;
    localparam int SUM_W  = 37;
    localparam int REM_W  = 58;
    localparam int Q_W    = 16;
    localparam int CNT_W  = $clog2(Q_W);

    localparam longint CA = 64'sd1686629713;
    localparam longint CB = 64'sd688904866;
    localparam longint CC = 64'sd76016977;

    localparam int THIRD_Q16      = 21845;
    localparam int INV_SQRT3_Q16  = 37837;
    localparam int HALF_SQRT3_Q16 = 56756;
    localparam int VBUS_FLOOR     = 256;

    typedef logic [15:0] t_sine_lut [0:SINE_ENTRIES];

    function automatic t_sine_lut build_sine();
        t_sine_lut lut;
        longint    x;
        longint    x2;
        longint    t;
        for (int k = 0; k <= SINE_ENTRIES; k++) begin
            x  = (longint'(k) * 65536) / SINE_ENTRIES;
            x2 = (x * x) >>> 16;
            t  = CB - ((CC * x2) >>> 16);
            t  = CA - ((t * x2) >>> 16);
            t  = (t * x) >>> 16;
            t  = (t + 16384) >>> 15;
            lut[k] = (t > 32767) ? 16'd32767 : 16'(t);
        end
        return lut;
    endfunction

    localparam t_sine_lut SINE_LUT = build_sine();

    typedef enum logic [2:0] {
        REG_KP_D,
        REG_KI_TS_D,
        REG_KP_Q,
        REG_KI_TS_Q,
        REG_OUT_MAX_D,
        REG_OUT_MIN_D,
        REG_OUT_MAX_Q,
        REG_OUT_MIN_Q
    } t_reg;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_RD_SIN,
        OP_RD_COS,
        OP_CAP_COS,
        OP_PD1,
        OP_PD2,
        OP_PQ1,
        OP_PQ2,
        OP_PID,
        OP_KID,
        OP_UD,
        OP_KIQ,
        OP_UQ,
        OP_IP1,
        OP_IP2,
        OP_IP3,
        OP_IP4,
        OP_IP5,
        OP_VB1,
        OP_VBC,
        OP_MM,
        OP_DIV_INIT
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
        logic div_step;
        logic out_load;
    } t_cmd;

    function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] v);
        if (v > PROD_W'(32767)) begin
            return 16'sh7fff;
        end else if (v < -PROD_W'(32768)) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(64'sh7fffffff)) begin
            return 32'sh7fffffff;
        end else if (v < -SUM_W'(64'sh80000000)) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

endpackage
`default_nettype wire

FILE: design/focsv_div_lane.sv
// One restoring divider lane: turns a centred phase voltage into a saturated duty quotient.
`default_nettype none
module focsv_div_lane
    import focsv_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_init,
    input  wire logic                    i_step,
    input  wire logic signed [N_W-1:0]   i_n,
    input  wire logic        [15:0]      i_vbus,
    output logic             [Q_W-1:0]   o_q
);

    logic signed [REM_W-1:0] r_rem;
    logic        [Q_W-1:0]   r_q;
    logic signed [REM_W-1:0] num;
    logic signed [REM_W-1:0] den;
    logic                    ge;

    // Offset numerator 256n + 65535V; quotient then sits in 0..65535 when in range
    always_comb begin
        num = (REM_W'(i_n) <<< 8) + $signed(REM_W'({i_vbus, 16'b0}))
              - $signed(REM_W'(i_vbus));
        den = $signed(REM_W'({i_vbus, 16'b0}));
        ge  = (r_rem >= den);
    end

    // A negative start never subtracts and an oversized one always does: both saturate
    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_rem <= num;
            r_q   <= '0;
        end else if (i_step) begin
            r_rem <= (ge ? (r_rem - den) : r_rem) <<< 1;
            r_q   <= {r_q[Q_W-2:0], ge};
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

FILE: design/focsv_dp.sv
// Datapath: input capture, sine table, shared multiplier, PI state, divider lanes, outputs.
`default_nettype none
module focsv_dp
    import focsv_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_idx,
    input  wire logic [23:0]          i_cfg_data,
    input  wire logic signed [15:0]   i_phase_a_current,
    input  wire logic signed [15:0]   i_phase_b_current,
    input  wire logic signed [15:0]   i_phase_c_current,
    input  wire logic        [15:0]   i_elec_angle,
    input  wire logic        [15:0]   i_bus_voltage,
    input  wire logic signed [15:0]   i_d_target,
    input  wire logic signed [15:0]   i_q_target,
    output logic signed [15:0]        o_d_current,
    output logic signed [15:0]        o_q_current,
    output logic signed [15:0]        o_d_voltage,
    output logic signed [15:0]        o_q_voltage,
    output logic        [15:0]        o_duty_phase_a,
    output logic        [15:0]        o_duty_phase_b,
    output logic        [15:0]        o_duty_phase_c
);

    // Configuration
    logic        [23:0] r_kp_d, r_ki_d, r_kp_q, r_ki_q;
    logic signed [15:0] r_max_d, r_min_d, r_max_q, r_min_q;

    // State
    logic signed [31:0] r_integ_d, r_integ_q;

    // Captured request
    logic signed [15:0] r_ia, r_ib, r_ic, r_dt, r_qt;
    logic        [15:0] r_vbus;
    logic [ADDR_W-1:0]  r_sin_addr, r_cos_addr;
    logic               r_sin_neg, r_cos_neg;

    // Working registers
    logic        [15:0]       r_rom;
    logic signed [PROD_W-1:0] r_prod, r_acc;
    logic signed [16:0]       r_al, r_be;
    logic signed [15:0]       r_s, r_c, r_id, r_iq, r_vd, r_vq;
    logic signed [U_W-1:0]    r_u;
    logic signed [V_W-1:0]    r_va, r_vbt, r_vb, r_vc;
    logic signed [N_W-1:0]    r_na, r_nb, r_nc;

    // Output holding registers
    logic signed [15:0] r_o_id, r_o_iq, r_o_vd, r_o_vq;
    logic        [15:0] r_o_da, r_o_db, r_o_dc;

    logic [ANGLE_BITS-1:0]       ang;
    logic [ANGLE_BITS+IDX_W-1:0] ang_sc;
    logic [IDX_W-1:0]            idx;
    logic [1:0]                  quad_s, quad_c;
    logic [K_W-1:0]              offs;
    logic [ADDR_W-1:0]           rom_addr;
    logic signed [15:0]          rom_signed;
    logic signed [18:0]          clarke_x;
    logic signed [16:0]          clarke_y;
    logic signed [16:0]          e_d, e_q;
    logic signed [MUL_W-1:0]     mul_a, mul_b;
    logic signed [PROD_W-1:0]    rnd16, park_d, park_q, inv_a, inv_b, vb_t, vc_t;
    logic                        pi_q_axis;
    logic signed [15:0]          pi_hi, pi_lo;
    logic signed [31:0]          pi_integ;
    logic signed [U_W-1:0]       pi_hi_s, pi_lo_s, pi_rnd;
    logic                        pi_at_hi, pi_at_lo;
    logic signed [15:0]          pi_v;
    logic signed [SUM_W-1:0]     pi_sum;
    logic signed [V_W-1:0]       v_max, v_min;
    logic                        div_init;
    logic [Q_W-1:0]              q_a, q_b, q_c;

    // Sine and cosine table addresses from the angle
    always_comb begin
        ang      = ANGLE_BITS'(i_elec_angle);
        ang_sc   = {ang, {IDX_W{1'b0}}};
        idx      = ang_sc[ANGLE_BITS +: IDX_W];
        quad_s   = idx[IDX_W-1 -: 2];
        quad_c   = quad_s + 2'd1;
        offs     = idx[K_W-1:0];
        rom_addr = (i_cmd.op == OP_RD_SIN) ? r_sin_addr : r_cos_addr;
    end

    always_comb begin
        rom_signed = (i_cmd.op == OP_RD_COS) ?
                     (r_sin_neg ? -$signed({1'b0, r_rom[14:0]}) : $signed({1'b0, r_rom[14:0]})) :
                     (r_cos_neg ? -$signed({1'b0, r_rom[14:0]}) : $signed({1'b0, r_rom[14:0]}));
        clarke_x = ($signed(19'(r_ia)) <<< 1) - 19'(r_ib) - 19'(r_ic);
        clarke_y = 17'(r_ib) - 17'(r_ic);
        e_d      = 17'(r_dt) - 17'(r_id);
        e_q      = 17'(r_qt) - 17'(r_iq);
    end

    // Operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_RD_SIN: begin mul_a = MUL_W'(clarke_x); mul_b = MUL_W'(THIRD_Q16);     end
            OP_RD_COS: begin mul_a = MUL_W'(clarke_y); mul_b = MUL_W'(INV_SQRT3_Q16); end
            OP_PD1:    begin mul_a = MUL_W'(r_al); mul_b = MUL_W'(r_c); end
            OP_PD2:    begin mul_a = MUL_W'(r_be); mul_b = MUL_W'(r_s); end
            OP_PQ1:    begin mul_a = MUL_W'(r_be); mul_b = MUL_W'(r_c); end
            OP_PQ2:    begin mul_a = MUL_W'(r_al); mul_b = MUL_W'(r_s); end
            OP_PID:    begin mul_a = MUL_W'({1'b0, r_kp_d}); mul_b = MUL_W'(e_d); end
            OP_KID:    begin mul_a = MUL_W'({1'b0, r_ki_d}); mul_b = MUL_W'(e_d); end
            OP_UD:     begin mul_a = MUL_W'({1'b0, r_kp_q}); mul_b = MUL_W'(e_q); end
            OP_KIQ:    begin mul_a = MUL_W'({1'b0, r_ki_q}); mul_b = MUL_W'(e_q); end
            OP_IP1:    begin mul_a = MUL_W'(r_vd); mul_b = MUL_W'(r_c); end
            OP_IP2:    begin mul_a = MUL_W'(r_vq); mul_b = MUL_W'(r_s); end
            OP_IP3:    begin mul_a = MUL_W'(r_vd); mul_b = MUL_W'(r_s); end
            OP_IP4:    begin mul_a = MUL_W'(r_vq); mul_b = MUL_W'(r_c); end
            OP_VB1:    begin mul_a = MUL_W'(HALF_SQRT3_Q16); mul_b = MUL_W'(r_vbt); end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Rounding, PI decision and zero-sequence terms
    always_comb begin
        rnd16  = r_prod + PROD_W'(32768);
        park_d = r_acc + r_prod + PROD_W'(16384);
        park_q = r_acc - r_prod + PROD_W'(16384);
        inv_a  = r_acc - r_prod + PROD_W'(64);
        inv_b  = r_acc + r_prod + PROD_W'(64);
        vb_t   = r_prod - (PROD_W'(r_va) <<< 15);
        vc_t   = -r_prod - (PROD_W'(r_va) <<< 15);

        pi_q_axis = (i_cmd.op == OP_UQ);
        pi_hi     = pi_q_axis ? r_max_q : r_max_d;
        pi_lo     = pi_q_axis ? r_min_q : r_min_d;
        pi_integ  = pi_q_axis ? r_integ_q : r_integ_d;
        pi_hi_s   = U_W'(pi_hi) <<< 8;
        pi_lo_s   = U_W'(pi_lo) <<< 8;
        pi_at_hi  = (r_u >= pi_hi_s);
        pi_at_lo  = (r_u <= pi_lo_s);
        pi_rnd    = (r_u + U_W'(128)) >>> 8;
        pi_v      = pi_at_hi ? pi_hi : (pi_at_lo ? pi_lo : 16'(pi_rnd));
        pi_sum    = SUM_W'(r_prod >>> 8) + SUM_W'(pi_integ);

        v_max = r_va;
        v_min = r_va;
        if (r_vb > v_max) v_max = r_vb;
        if (r_vc > v_max) v_max = r_vc;
        if (r_vb < v_min) v_min = r_vb;
        if (r_vc < v_min) v_min = r_vc;
    end

    // Configuration and integrators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_d    <= '0;
            r_ki_d    <= '0;
            r_kp_q    <= '0;
            r_ki_q    <= '0;
            r_max_d   <= '0;
            r_min_d   <= '0;
            r_max_q   <= '0;
            r_min_q   <= '0;
            r_integ_d <= '0;
            r_integ_q <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_idx))
                    REG_KP_D:      r_kp_d  <= i_cfg_data;
                    REG_KI_TS_D:   r_ki_d  <= i_cfg_data;
                    REG_KP_Q:      r_kp_q  <= i_cfg_data;
                    REG_KI_TS_Q:   r_ki_q  <= i_cfg_data;
                    REG_OUT_MAX_D: r_max_d <= i_cfg_data[15:0];
                    REG_OUT_MIN_D: r_min_d <= i_cfg_data[15:0];
                    REG_OUT_MAX_Q: r_max_q <= i_cfg_data[15:0];
                    REG_OUT_MIN_Q: r_min_q <= i_cfg_data[15:0];
                    default:       r_kp_d  <= r_kp_d;
                endcase
            end
            // Hold the integrator while the output sits at a limit
            if ((i_cmd.op == OP_UD) && !pi_at_hi && !pi_at_lo) begin
                r_integ_d <= sat32(pi_sum);
            end
            if ((i_cmd.op == OP_UQ) && !pi_at_hi && !pi_at_lo) begin
                r_integ_q <= sat32(pi_sum);
            end
        end
    end

    // Working datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_rom  <= SINE_LUT[rom_addr];
        if (i_cmd.load) begin
            r_ia       <= i_phase_a_current;
            r_ib       <= i_phase_b_current;
            r_ic       <= i_phase_c_current;
            r_dt       <= i_d_target;
            r_qt       <= i_q_target;
            r_vbus     <= (i_bus_voltage < 16'(VBUS_FLOOR)) ? 16'(VBUS_FLOOR) : i_bus_voltage;
            r_sin_addr <= quad_s[0] ? (ADDR_W'(SINE_ENTRIES) - ADDR_W'(offs)) : ADDR_W'(offs);
            r_cos_addr <= quad_c[0] ? (ADDR_W'(SINE_ENTRIES) - ADDR_W'(offs)) : ADDR_W'(offs);
            r_sin_neg  <= quad_s[1];
            r_cos_neg  <= quad_c[1];
        end
        case (i_cmd.op)
            OP_RD_COS: begin
                r_al <= 17'(rnd16 >>> 16);
                r_s  <= rom_signed;
            end
            OP_CAP_COS: begin
                r_be <= 17'(rnd16 >>> 16);
                r_c  <= rom_signed;
            end
            OP_PD2:  r_acc <= r_prod;
            OP_PQ1:  r_id  <= sat16(park_d >>> 15);
            OP_PQ2:  r_acc <= r_prod;
            OP_PID:  r_iq  <= sat16(park_q >>> 15);
            OP_KID:  r_u   <= U_W'(r_prod >>> 8) + U_W'(r_integ_d);
            OP_UD:   r_vd  <= pi_v;
            OP_KIQ:  r_u   <= U_W'(r_prod >>> 8) + U_W'(r_integ_q);
            OP_UQ:   r_vq  <= pi_v;
            OP_IP2:  r_acc <= r_prod;
            OP_IP3:  r_va  <= V_W'(inv_a >>> 7);
            OP_IP4:  r_acc <= r_prod;
            OP_IP5:  r_vbt <= V_W'(inv_b >>> 7);
            OP_VBC: begin
                r_vb <= V_W'(vb_t >>> 16);
                r_vc <= V_W'(vc_t >>> 16);
            end
            OP_MM: begin
                r_na <= (N_W'(r_va) <<< 1) - N_W'(v_max) - N_W'(v_min);
                r_nb <= (N_W'(r_vb) <<< 1) - N_W'(v_max) - N_W'(v_min);
                r_nc <= (N_W'(r_vc) <<< 1) - N_W'(v_max) - N_W'(v_min);
            end
            default: r_acc <= r_acc;
        endcase
        if (i_cmd.out_load) begin
            r_o_id <= r_id;
            r_o_iq <= r_iq;
            r_o_vd <= r_vd;
            r_o_vq <= r_vq;
            r_o_da <= ~q_a;
            r_o_db <= ~q_b;
            r_o_dc <= ~q_c;
        end
    end

    assign div_init = (i_cmd.op == OP_DIV_INIT);

    focsv_div_lane u_div_a (
        .i_clk  (i_clk),
        .i_init (div_init),
        .i_step (i_cmd.div_step),
        .i_n    (r_na),
        .i_vbus (r_vbus),
        .o_q    (q_a)
    );

    focsv_div_lane u_div_b (
        .i_clk  (i_clk),
        .i_init (div_init),
        .i_step (i_cmd.div_step),
        .i_n    (r_nb),
        .i_vbus (r_vbus),
        .o_q    (q_b)
    );

    focsv_div_lane u_div_c (
        .i_clk  (i_clk),
        .i_init (div_init),
        .i_step (i_cmd.div_step),
        .i_n    (r_nc),
        .i_vbus (r_vbus),
        .o_q    (q_c)
    );

    assign o_d_current    = r_o_id;
    assign o_q_current    = r_o_iq;
    assign o_d_voltage    = r_o_vd;
    assign o_q_voltage    = r_o_vq;
    assign o_duty_phase_a = r_o_da;
    assign o_duty_phase_b = r_o_db;
    assign o_duty_phase_c = r_o_dc;

endmodule
`default_nettype wire

FILE: design/focsv_ctrl.sv
// Controller: sequences the datapath operations and runs both handshakes.
`default_nettype none
module focsv_ctrl
    import focsv_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DIV,
        S_FIN
    } t_state;

    t_state           r_state;
    t_op              r_op;
    logic [CNT_W-1:0] r_cnt;
    logic             r_valid;
    logic             out_free;

    assign out_free = !r_valid || !i_stall;

    always_comb begin
        o_cmd.load     = (r_state == S_IDLE) && i_valid;
        o_cmd.op       = (r_state == S_RUN) ? r_op : OP_NONE;
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.out_load = (r_state == S_FIN) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_NONE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            // Raise valid with a fresh result, else drop it once the result is taken
            if ((r_state == S_FIN) && out_free) begin
                r_valid <= 1'b1;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_RUN;
                        r_op    <= OP_RD_SIN;
                    end
                end
                S_RUN: begin
                    if (r_op == OP_DIV_INIT) begin
                        r_state <= S_DIV;
                        r_cnt   <= '0;
                    end else begin
                        r_op <= t_op'(r_op + 1'b1);
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(Q_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // Hold the result until the output register is free
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule
`default_nettype wire

FILE: design/foc_current_loop_svpwm.sv
// Top level of the FOC current loop with space-vector PWM.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------
//  request | in        | i_valid / o_stall  | phase currents, angle, bus, d/q target
//  result  | out       | o_valid / i_stall  | d/q current, d/q voltage, three duties
//  config  | in        | i_cfg_we           | i_cfg_idx, i_cfg_data (no read-back)
//
// From acceptance until the controller is idle again, a request goes through the datapath
// operations in order, sharing the single multiplier (sine and cosine read one after the
// other from the table port), the steps of the three parallel divider lanes and the load
// of the result register. o_stall is high whenever the controller is not idle, so the next
// request is taken only once the previous one has loaded its result.
// Synchronous active-low reset clears both integrators, the gains and limits, and the
// controller. A stalled result holds in the output register; a new request is taken
// while it waits, and the next result waits in the controller until it is taken.
`default_nettype none
module foc_current_loop_svpwm
    import focsv_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_phase_a_current,
    input  wire logic signed [15:0] i_phase_b_current,
    input  wire logic signed [15:0] i_phase_c_current,
    input  wire logic        [15:0] i_elec_angle,
    input  wire logic        [15:0] i_bus_voltage,
    input  wire logic signed [15:0] i_d_target,
    input  wire logic signed [15:0] i_q_target,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [15:0]      o_d_current,
    output logic signed [15:0]      o_q_current,
    output logic signed [15:0]      o_d_voltage,
    output logic signed [15:0]      o_q_voltage,
    output logic        [15:0]      o_duty_phase_a,
    output logic        [15:0]      o_duty_phase_b,
    output logic        [15:0]      o_duty_phase_c
);

    t_cmd cmd;

    // Sequence the work of one request and drive both handshakes
    focsv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    // Transforms, regulators, modulation and the result register
    focsv_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_phase_a_current (i_phase_a_current),
        .i_phase_b_current (i_phase_b_current),
        .i_phase_c_current (i_phase_c_current),
        .i_elec_angle      (i_elec_angle),
        .i_bus_voltage     (i_bus_voltage),
        .i_d_target        (i_d_target),
        .i_q_target        (i_q_target),
        .o_d_current       (o_d_current),
        .o_q_current       (o_q_current),
        .o_d_voltage       (o_d_voltage),
        .o_q_voltage       (o_q_voltage),
        .o_duty_phase_a    (o_duty_phase_a),
        .o_duty_phase_b    (o_duty_phase_b),
        .o_duty_phase_c    (o_duty_phase_c)
    );

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the FOC current loop with SVPWM, with its own bit-exact predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import focsv_pkg::*;

    typedef struct packed {
        logic signed [15:0] ia;
        logic signed [15:0] ib;
        logic signed [15:0] ic;
        logic        [15:0] ang;
        logic        [15:0] vbus;
        logic signed [15:0] dt;
        logic signed [15:0] qt;
    } t_request;

    typedef struct packed {
        logic signed [15:0] id;
        logic signed [15:0] iq;
        logic signed [15:0] vd;
        logic signed [15:0] vq;
        logic        [15:0] da;
        logic        [15:0] db;
        logic        [15:0] dc;
    } t_period;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [23:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_phase_a_current = '0;
    logic signed [15:0] i_phase_b_current = '0;
    logic signed [15:0] i_phase_c_current = '0;
    logic        [15:0] i_elec_angle = '0;
    logic        [15:0] i_bus_voltage = '0;
    logic signed [15:0] i_d_target = '0;
    logic signed [15:0] i_q_target = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_d_current;
    logic signed [15:0] o_q_current;
    logic signed [15:0] o_d_voltage;
    logic signed [15:0] o_q_voltage;
    logic        [15:0] o_duty_phase_a;
    logic        [15:0] o_duty_phase_b;
    logic        [15:0] o_duty_phase_c;

    foc_current_loop_svpwm i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state: quarter-wave table, gains, limits and both integrators
    longint  quarter_sine [0:SINE_ENTRIES];
    longint  gain_p_d, gain_i_d, gain_p_q, gain_i_q;
    longint  lim_hi_d, lim_lo_d, lim_hi_q, lim_lo_q;
    longint  acc_d, acc_q;

    t_period pending_periods [$];
    int      err_count = 0;
    int      accepted = 0;
    bit      hold_off_req = 1'b0;

    // Floor division by a positive divisor
    function automatic longint floor_div(longint n, longint d);
        if (n >= 0) begin
            return n / d;
        end
        return -((-n + d - 1) / d);
    endfunction

    function automatic longint round_shift(longint v, int s);
        return floor_div(v + (longint'(1) << (s - 1)), longint'(1) << s);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic fill_quarter_sine();
        longint x, x2, t;
        for (int k = 0; k <= SINE_ENTRIES; k++) begin
            x  = (longint'(k) * 65536) / SINE_ENTRIES;
            x2 = (x * x) >>> 16;
            t  = 64'sd688904866 - ((64'sd76016977 * x2) >>> 16);
            t  = 64'sd1686629713 - ((t * x2) >>> 16);
            t  = (t * x) >>> 16;
            t  = (t + 16384) >>> 15;
            quarter_sine[k] = (t > 32767) ? 32767 : t;
        end
    endtask

    function automatic longint sine_at(longint i);
        longint quad, off, v;
        i    = i % (4 * SINE_ENTRIES);
        quad = i / SINE_ENTRIES;
        off  = i % SINE_ENTRIES;
        v    = quad[0] ? quarter_sine[SINE_ENTRIES - off] : quarter_sine[off];
        return (quad >= 2) ? -v : v;
    endfunction

    // PI regulator with clamp anti-windup: hold the integrator at either limit
    function automatic longint pi_axis(longint e, longint kp, longint ki, longint hi,
                                       longint lo, inout longint integ);
        longint u;
        u = floor_div(kp * e, 256) + integ;
        if (u >= hi * 256) begin
            return hi;
        end
        if (u <= lo * 256) begin
            return lo;
        end
        integ = clamp(integ + floor_div(ki * e, 256), -64'sd2147483648, 64'sd2147483647);
        return round_shift(u, 8);
    endfunction

    function automatic t_period predict_period(t_request r);
        t_period p;
        longint  idx, s, c, al, be, id, iq, vd, vq, va, vbt, vmax, vmin, vb, n, duty;
        longint  v [3];
        idx = (longint'(r.ang) * 4 * SINE_ENTRIES) >>> ANGLE_BITS;
        s   = sine_at(idx);
        c   = sine_at(idx + SINE_ENTRIES);
        vb  = (r.vbus < 256) ? 256 : longint'(r.vbus);
        al  = round_shift((2 * longint'(r.ia) - r.ib - r.ic) * 21845, 16);
        be  = round_shift((longint'(r.ib) - r.ic) * 37837, 16);
        id  = clamp(round_shift(al * c + be * s, 15), -32768, 32767);
        iq  = clamp(round_shift(be * c - al * s, 15), -32768, 32767);
        vd  = pi_axis(longint'(r.dt) - id, gain_p_d, gain_i_d, lim_hi_d, lim_lo_d, acc_d);
        vq  = pi_axis(longint'(r.qt) - iq, gain_p_q, gain_i_q, lim_hi_q, lim_lo_q, acc_q);
        va  = round_shift(vd * c - vq * s, 7);
        vbt = round_shift(vd * s + vq * c, 7);
        v[0] = va;
        v[1] = floor_div(-32768 * va + 56756 * vbt, 65536);
        v[2] = floor_div(-32768 * va - 56756 * vbt, 65536);
        vmax = v[0];
        vmin = v[0];
        for (int j = 1; j < 3; j++) begin
            if (v[j] > vmax) vmax = v[j];
            if (v[j] < vmin) vmin = v[j];
        end
        p.id = 16'(id);
        p.iq = 16'(iq);
        p.vd = 16'(vd);
        p.vq = 16'(vq);
        for (int j = 0; j < 3; j++) begin
            n    = 2 * v[j] - vmax - vmin;
            duty = clamp(32768 - floor_div(256 * n + vb, 2 * vb), 0, 65535);
            if (j == 0) p.da = 16'(duty);
            else if (j == 1) p.db = 16'(duty);
            else p.dc = 16'(duty);
        end
        return p;
    endfunction

    function automatic t_request mk_request(int a, int b, int c, int ang, int vbus,
                                            int dt, int qt);
        t_request r;
        r.ia   = 16'(a);
        r.ib   = 16'(b);
        r.ic   = 16'(c);
        r.ang  = 16'(ang);
        r.vbus = 16'(vbus);
        r.dt   = 16'(dt);
        r.qt   = 16'(qt);
        return r;
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'hffff;
        endcase
    endfunction

    // Mostly balanced operating points; some raw noise and some extremes
    function automatic t_request random_request();
        t_request r;
        int       a, b, kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            r = t_request'({$urandom, $urandom, $urandom, $urandom});
        end else if (kind == 1) begin
            r = {pick_extreme(), pick_extreme(), pick_extreme(), 16'($urandom),
                 ($urandom_range(0, 1) ? pick_extreme() : 16'($urandom_range(0, 300))),
                 pick_extreme(), pick_extreme()};
        end else begin
            a = $urandom_range(0, 5120) - 2560;
            b = $urandom_range(0, 5120) - 2560;
            r = mk_request(a, b, -(a + b), $urandom, $urandom_range(2000, 12000),
                           $urandom_range(0, 5120) - 2560, $urandom_range(0, 5120) - 2560);
        end
        return r;
    endfunction

    // Write one register; call only with the block idle
    task automatic write_reg(t_reg idx, logic [23:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_KP_D:      gain_p_d = data;
            REG_KI_TS_D:   gain_i_d = data;
            REG_KP_Q:      gain_p_q = data;
            REG_KI_TS_Q:   gain_i_q = data;
            REG_OUT_MAX_D: lim_hi_d = longint'(signed'(data[15:0]));
            REG_OUT_MIN_D: lim_lo_d = longint'(signed'(data[15:0]));
            REG_OUT_MAX_Q: lim_hi_q = longint'(signed'(data[15:0]));
            default:       lim_lo_q = longint'(signed'(data[15:0]));
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_periods.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (45) @(posedge i_clk);
    endtask

    task automatic load_setting(logic [23:0] kpd, logic [23:0] kid, logic [23:0] kpq,
                                logic [23:0] kiq, logic [15:0] hid, logic [15:0] lod,
                                logic [15:0] hiq, logic [15:0] loq);
        drain();
        write_reg(REG_KP_D, kpd);
        write_reg(REG_KI_TS_D, kid);
        write_reg(REG_KP_Q, kpq);
        write_reg(REG_KI_TS_Q, kiq);
        write_reg(REG_OUT_MAX_D, {8'($urandom), hid});
        write_reg(REG_OUT_MIN_D, {8'($urandom), lod});
        write_reg(REG_OUT_MAX_Q, {8'($urandom), hiq});
        write_reg(REG_OUT_MIN_Q, {8'($urandom), loq});
    endtask

    // Present one request and hold it until taken; entered just after a rising edge
    task automatic offer(t_request r, bit typed, t_period want);
        t_period p;
        i_valid           <= 1'b1;
        i_phase_a_current <= r.ia;
        i_phase_b_current <= r.ib;
        i_phase_c_current <= r.ic;
        i_elec_angle      <= r.ang;
        i_bus_voltage     <= r.vbus;
        i_d_target        <= r.dt;
        i_q_target        <= r.qt;
        do @(posedge i_clk); while (o_stall);
        p = predict_period(r);
        pending_periods.push_back(typed ? want : p);
        accepted++;
        if (accepted == 600) hold_off_req = 1'b1;
    endtask

    // Sender: bursts of requests, most of them followed by a random gap
    task automatic run_random(int count);
        int burst;
        t_period none;
        none  = '0;
        burst = $urandom_range(1, 12);
        for (int n = 0; n < count; n++) begin
            offer(random_request(), 1'b0, none);
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 3) != 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 40)) @(posedge i_clk);
                end
            end
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver: check each taken result, stall on a pattern that changes now and then
    initial begin : receiver
        int      mode;
        int      left;
        int      hold;
        t_period got, want;
        mode = 0;
        left = 0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                got = {o_d_current, o_q_current, o_d_voltage, o_q_voltage,
                       o_duty_phase_a, o_duty_phase_b, o_duty_phase_c};
                if (pending_periods.size() == 0) begin
                    $error("result with nothing expected");
                    err_count++;
                end else begin
                    want = pending_periods.pop_front();
                    if (got.id !== want.id) begin
                        $error("d_current: expected %0d, got %0d", want.id, got.id);
                        err_count++;
                    end
                    if (got.iq !== want.iq) begin
                        $error("q_current: expected %0d, got %0d", want.iq, got.iq);
                        err_count++;
                    end
                    if (got.vd !== want.vd) begin
                        $error("d_voltage: expected %0d, got %0d", want.vd, got.vd);
                        err_count++;
                    end
                    if (got.vq !== want.vq) begin
                        $error("q_voltage: expected %0d, got %0d", want.vq, got.vq);
                        err_count++;
                    end
                    if (got.da !== want.da) begin
                        $error("duty_phase_a: expected %0d, got %0d", want.da, got.da);
                        err_count++;
                    end
                    if (got.db !== want.db) begin
                        $error("duty_phase_b: expected %0d, got %0d", want.db, got.db);
                        err_count++;
                    end
                    if (got.dc !== want.dc) begin
                        $error("duty_phase_c: expected %0d, got %0d", want.dc, got.dc);
                        err_count++;
                    end
                end
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold = 600;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(16, 200);
            end
            left--;
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else begin
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ~i_stall;
                endcase
            end
        end
    end

    initial begin : watchdog
        #20ms;
        $display("tb_top: errors");
        $finish;
    end

    initial begin : stimulus
        t_request dir_req [20];
        bit       dir_typed [20];
        t_period  idle_out;
        fill_quarter_sine();
        gain_p_d = 0; gain_i_d = 0; gain_p_q = 0; gain_i_q = 0;
        lim_hi_d = 0; lim_lo_d = 0; lim_hi_q = 0; lim_lo_q = 0;
        acc_d = 0; acc_q = 0;
        // After reset gains and limits are zero: no current gives zero d/q and half duty
        idle_out = {16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd32768, 16'd32768, 16'd32768};
        dir_req[0]  = mk_request(0, 0, 0, 0, 0, 0, 0);
        dir_req[1]  = mk_request(0, 0, 0, 65535, 65535, 32767, -32768);
        dir_req[2]  = mk_request(0, 0, 0, 16384, 255, -32768, 32767);
        dir_req[3]  = mk_request(32767, -32768, -32768, 0, 256, 0, 0);
        dir_req[4]  = mk_request(-32768, 32767, 32767, 16384, 65535, 0, 0);
        dir_req[5]  = mk_request(32767, 32767, 32767, 32768, 12800, 32767, 32767);
        dir_req[6]  = mk_request(-32768, -32768, -32768, 49152, 1, -32768, -32768);
        dir_req[7]  = mk_request(0, 32767, -32768, 65535, 3000, 0, 0);
        dir_req[8]  = mk_request(0, -32768, 32767, 8192, 3000, 0, 0);
        dir_req[9]  = mk_request(256, -128, -128, 1023, 3000, 256, 0);
        dir_req[10] = mk_request(256, -128, -128, 16383, 3000, 0, 256);
        dir_req[11] = mk_request(-256, 128, 128, 16385, 3000, 0, 0);
        dir_req[12] = mk_request(1000, -500, -500, 32767, 3000, 0, 0);
        dir_req[13] = mk_request(1000, -500, -500, 49151, 3000, 0, 0);
        dir_req[14] = mk_request(1000, -500, -500, 49153, 3000, 0, 0);
        dir_req[15] = mk_request(-1, -1, -1, 43690, 200, -1, -1);
        dir_req[16] = mk_request(1, 0, 0, 21845, 257, 1, 1);
        dir_req[17] = mk_request(32767, 0, -32768, 4096, 65280, 32767, -32768);
        dir_req[18] = mk_request(-21846, 21845, 1, 61440, 100, 0, 0);
        dir_req[19] = mk_request(0, 0, 0, 32768, 65535, 0, 0);
        for (int k = 0; k < 20; k++) dir_typed[k] = (k < 3) || (k == 19);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < 20; k++) begin
            offer(dir_req[k], dir_typed[k], idle_out);
            if (k % 4 == 3) begin
                i_valid <= 1'b0;
                repeat (k % 7 + 1) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
        @(posedge i_clk);

        // Walk through settings: typical, full range, crossed limits, tiny gains, random
        load_setting(24'h010000, 24'h000800, 24'h010000, 24'h000800,
                     16'sd3072, -16'sd3072, 16'sd3072, -16'sd3072);
        run_random(320);
        load_setting(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff,
                     16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        run_random(320);
        load_setting(24'h008000, 24'h001000, 24'h020000, 24'h000400,
                     -16'sd256, 16'sd256, 16'sd0, 16'sd512);
        run_random(320);
        load_setting(24'h000100, 24'h000001, 24'h000000, 24'h7fffff,
                     16'h7fff, 16'h8000, 16'sd1280, -16'sd1280);
        run_random(320);
        load_setting(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        run_random(310);
        load_setting(24'($urandom_range(0, 24'h040000)), 24'($urandom_range(0, 24'h004000)),
                     24'($urandom_range(0, 24'h040000)), 24'($urandom_range(0, 24'h004000)),
                     16'sd6400, -16'sd6400, 16'sd6400, -16'sd6400);
        run_random(310);

        drain();
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
